// ----- design/aes_pkg.sv -----
// Shared constants, result type and a character helper for the escape stripper.
package aes_pkg;

    // Widths of the byte path and of the per-window emitted-byte counter.
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 12;

    // Default cap on emitted bytes per window.
    localparam int OUT_LIMIT_DEFAULT = 4094;

    // Characters the parser reacts to.
    localparam logic [BYTE_W-1:0] CH_BEL       = 8'h07;
    localparam logic [BYTE_W-1:0] CH_TAB       = 8'h09;
    localparam logic [BYTE_W-1:0] CH_NL        = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_ESC       = 8'h1B;
    localparam logic [BYTE_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [BYTE_W-1:0] CH_LBRACKET  = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_RBRACKET  = 8'h5D;

    // One result as it travels from the parser to the output register.
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
        logic              present;
        logic              end_mark;
    } res_t;

    // True for an ASCII letter, upper or lower case.
    function automatic logic is_letter(input logic [BYTE_W-1:0] c);
        logic upper;
        logic lower;
        upper = (c >= 8'h41) && (c <= 8'h5A);
        lower = (c >= 8'h61) && (c <= 8'h7A);
        return upper || lower;
    endfunction

endpackage

// ----- design/aes_if.sv -----
// Handshake channels for the raw input bytes and the cleaned results.
interface aes_in_if
    import aes_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              end_of_text;

    modport source (output valid, output in_byte, output end_of_text, input ready);
    modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface aes_out_if
    import aes_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              byte_present;
    logic              end_mark;

    modport source (output valid, output out_byte, output byte_present, output end_mark,
                    input ready);
    modport sink   (input valid, input out_byte, input byte_present, input end_mark,
                    output ready);
endinterface

// ----- design/aes_in_stage.sv -----
// Input register: holds one accepted byte until the parser consumes it.
module aes_in_stage
    import aes_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    aes_in_if.sink            rx,
    input  logic              advance,
    output logic              held_valid,
    output logic [BYTE_W-1:0] held_byte,
    output logic              held_end
);

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              end_reg;
    logic              take;

    // A new item may enter when the register is empty or is being drained.
    assign rx.ready   = !valid_reg || advance;
    assign take       = rx.valid && rx.ready;
    assign valid_next = take ? 1'b1 : (advance ? 1'b0 : valid_reg);

    // Occupancy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= rx.in_byte;
            end_reg  <= rx.end_of_text;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;
    assign held_end   = end_reg;

endmodule

// ----- design/aes_parser.sv -----
// Escape-sequence state machine: decides what each byte emits and tracks window state.
module aes_parser
    import aes_pkg::*;
#(
    parameter int OUT_LIMIT = OUT_LIMIT_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [BYTE_W-1:0] cur_byte,
    input  logic              cur_end,
    output res_t              res
);

    localparam logic [CNT_W-1:0] LIMIT = CNT_W'(OUT_LIMIT);

    typedef enum logic [2:0] {
        MODE_TEXT    = 3'd0,
        MODE_ESC     = 3'd1,
        MODE_CSI     = 3'd2,
        MODE_OSC     = 3'd3,
        MODE_OSC_ESC = 3'd4
    } mode_t;

    mode_t             mode_reg;
    mode_t             mode_next;
    mode_t             mode_step;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [BYTE_W-1:0] last_reg;
    logic [BYTE_W-1:0] last_next;
    logic              emit;
    logic [BYTE_W-1:0] emit_byte;
    logic              space_wanted;
    logic              room;

    // A separating space is wanted only after text not ending in space or newline.
    assign space_wanted = (count_reg != '0) && (last_reg != CH_SPACE) && (last_reg != CH_NL);
    assign room         = count_reg < LIMIT;

    // Mode transition and emission for the current byte.
    always_comb
    begin
        mode_step = mode_reg;
        emit      = 1'b0;
        emit_byte = CH_SPACE;
        unique case (mode_reg)
            MODE_ESC:
            begin
                if (cur_byte == CH_LBRACKET)
                begin
                    mode_step = MODE_CSI;
                    emit      = space_wanted;
                end
                else if (cur_byte == CH_RBRACKET)
                begin
                    mode_step = MODE_OSC;
                    emit      = space_wanted;
                end
                else
                begin
                    mode_step = MODE_TEXT;
                end
            end
            MODE_CSI:
            begin
                if (is_letter(cur_byte))
                begin
                    mode_step = MODE_TEXT;
                end
            end
            MODE_OSC:
            begin
                if (cur_byte == CH_BEL)
                begin
                    mode_step = MODE_TEXT;
                end
                else if (cur_byte == CH_ESC)
                begin
                    mode_step = MODE_OSC_ESC;
                end
            end
            MODE_OSC_ESC:
            begin
                if ((cur_byte == CH_BACKSLASH) || (cur_byte == CH_BEL))
                begin
                    mode_step = MODE_TEXT;
                end
                else if (cur_byte != CH_ESC)
                begin
                    mode_step = MODE_OSC;
                end
            end
            default:
            begin
                if (cur_byte == CH_ESC)
                begin
                    mode_step = MODE_ESC;
                end
                else
                begin
                    mode_step = MODE_TEXT;
                    emit      = (cur_byte >= CH_SPACE) || (cur_byte == CH_NL)
                                || (cur_byte == CH_TAB);
                    emit_byte = cur_byte;
                end
            end
        endcase
        // Once the window is full, bytes change no mode and emit nothing.
        if (!room)
        begin
            mode_step = mode_reg;
            emit      = 1'b0;
        end
    end

    // Next state: the last byte of a window returns everything to reset.
    always_comb
    begin
        mode_next  = mode_reg;
        count_next = count_reg;
        last_next  = last_reg;
        if (step)
        begin
            if (cur_end)
            begin
                mode_next  = MODE_TEXT;
                count_next = '0;
                last_next  = '0;
            end
            else
            begin
                mode_next = mode_step;
                if (emit)
                begin
                    count_next = count_reg + CNT_W'(1);
                    last_next  = emit_byte;
                end
            end
        end
    end

    // Window state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_TEXT;
            count_reg <= '0;
            last_reg  <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
            last_reg  <= last_next;
        end
    end

    // Result for this byte; a bare end marker carries a zero byte.
    assign res.valid    = emit || cur_end;
    assign res.present  = emit;
    assign res.data     = emit ? emit_byte : '0;
    assign res.end_mark = cur_end;

endmodule

// ----- design/aes_out_stage.sv -----
// Output register: holds one result until the receiver takes it.
module aes_out_stage
    import aes_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     load,
    input  res_t     res,
    output logic     room,
    aes_out_if.source tx
);

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              present_reg;
    logic              end_reg;

    // The register can take a result when empty or when its item leaves now.
    assign room       = !valid_reg || tx.ready;
    assign valid_next = load ? 1'b1 : (tx.ready ? 1'b0 : valid_reg);

    // Occupancy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg    <= res.data;
            present_reg <= res.present;
            end_reg     <= res.end_mark;
        end
    end

    assign tx.valid        = valid_reg;
    assign tx.out_byte     = byte_reg;
    assign tx.byte_present = present_reg;
    assign tx.end_mark     = end_reg;

endmodule

// ----- design/ansi_escape_stripper.sv -----
// Top level of the streaming terminal-text escape stripper.
//
// Bytes arrive on rx, one item per byte, with end_of_text on the last byte of
// a window. Cleaned bytes leave on tx; CSI and OSC sequences, other two-byte
// escapes and control bytes other than newline and tab are removed, and one
// space stands in for each CSI or OSC after text that did not end in
// space or newline. At most OUT_LIMIT bytes are emitted per window. The last
// byte of a window always yields one item with end_mark set, with byte_present
// low if it carried no byte, and the window state then clears.
// A byte accepted on rx waits in the input register, and its result is loaded
// into the output register once that register has room. Throughput is one
// byte per cycle while tx does not stall.
// Bytes that emit nothing leave no item. When tx stalls, the output register
// holds its item and rx keeps accepting until the input register also fills.
// Reset clears both registers and returns the parser to text mode with an
// empty window; the block takes items in the first cycle after reset.
module ansi_escape_stripper
    import aes_pkg::*;
#(
    parameter int OUT_LIMIT = OUT_LIMIT_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    aes_in_if.sink    rx,
    aes_out_if.source tx
);

    logic              held_valid;
    logic [BYTE_W-1:0] held_byte;
    logic              held_end;
    logic              out_room;
    logic              step;
    res_t              res;

    // The held byte is processed whenever the output side has space for its result.
    assign step = held_valid && out_room;

    aes_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .advance    (step),
        .held_valid (held_valid),
        .held_byte  (held_byte),
        .held_end   (held_end)
    );

    aes_parser #(
        .OUT_LIMIT (OUT_LIMIT)
    ) u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .cur_byte (held_byte),
        .cur_end  (held_end),
        .res      (res)
    );

    aes_out_stage u_out_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (step && res.valid),
        .res   (res),
        .room  (out_room),
        .tx    (tx)
    );

endmodule

// ----- bench/tb.sv -----
// Self-checking testbench for the terminal escape stripper: table-driven and random windows.
`timescale 1ns / 100ps

module tb;
    import aes_pkg::*;

    localparam int LIMIT        = OUT_LIMIT_DEFAULT;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 850;
    localparam int TAIL_CYCLES  = 8;

    // Parser modes of the predictor.
    typedef enum logic [2:0] {PM_TEXT, PM_ESC, PM_CSI, PM_OSC, PM_OSC_ESC} pmode_t;

    // How a table row gets its expectation.
    typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_ITEM} exp_kind_t;

    typedef struct packed {
        logic [7:0] b;
        logic       present;
        logic       mark;
    } clean_t;

    typedef struct {
        logic [7:0] b;
        logic       eot;
        exp_kind_t  kind;
        logic [7:0] t_b;
        logic       t_present;
        logic       t_mark;
    } dir_row_t;

    logic clk;
    logic rst_n;

    aes_in_if  rx_if ();
    aes_out_if tx_if ();

    ansi_escape_stripper #(.OUT_LIMIT(LIMIT)) u_top
    (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_if),
        .tx    (tx_if)
    );

    // Window state of the predictor.
    pmode_t      win_mode;
    logic [11:0] win_count;
    logic [7:0]  win_last;

    clean_t      cleaned_q [$];
    logic [7:0]  win_q [$];
    int          fail_count;
    int          results_seen;
    int          burst_left;
    int          cycle_n;

    // Directed windows: extremes, every sequence kind and the window-end cases.
    dir_row_t dir_tab [25] = '{
        '{8'h00, 1'b0, EXP_NONE,  8'h00, 1'b0, 1'b0},
        '{8'hFF, 1'b0, EXP_ITEM,  8'hFF, 1'b1, 1'b0},
        '{8'h09, 1'b0, EXP_ITEM,  8'h09, 1'b1, 1'b0},
        '{8'h1B, 1'b0, EXP_MODEL, 8'h00, 1'b0, 1'b0},
        '{8'h5B, 1'b0, EXP_MODEL, 8'h00, 1'b0, 1'b0},
        '{8'h31, 1'b0, EXP_MODEL, 8'h00, 1'b0, 1'b0},
        '{8'h6D, 1'b0, EXP_MODEL, 8'h00, 1'b0, 1'b0},
        '{8'h0A, 1'b0, EXP_MODEL, 8'h00, 1'b0, 1'b0},
        '{8'h1B, 1'b0, EXP_MODEL, 8'h00, 1'b0, 1'b0},
        '{8'h5D, 1'b0, EXP_MODEL, 8'h00, 1'b0, 1'b0},
        '{8'h1B, 1'b0, EXP_MODEL, 8'h00, 1'b0, 1'b0},
        '{8'h1B, 1'b0, EXP_MODEL, 8'h00, 1'b0, 1'b0},
        '{8'h07, 1'b0, EXP_MODEL, 8'h00, 1'b0, 1'b0},
        '{8'h7A, 1'b0, EXP_MODEL, 8'h00, 1'b0, 1'b0},
        '{8'h1B, 1'b0, EXP_MODEL, 8'h00, 1'b0, 1'b0},
        '{8'h1B, 1'b0, EXP_MODEL, 8'h00, 1'b0, 1'b0},
        '{8'h41, 1'b0, EXP_MODEL, 8'h00, 1'b0, 1'b0},
        '{8'h1B, 1'b0, EXP_MODEL, 8'h00, 1'b0, 1'b0},
        '{8'h5B, 1'b0, EXP_MODEL, 8'h00, 1'b0, 1'b0},
        '{8'h7F, 1'b1, EXP_ITEM,  8'h00, 1'b0, 1'b1},
        '{8'h1B, 1'b1, EXP_ITEM,  8'h00, 1'b0, 1'b1},
        '{8'h1B, 1'b0, EXP_MODEL, 8'h00, 1'b0, 1'b0},
        '{8'h5D, 1'b0, EXP_MODEL, 8'h00, 1'b0, 1'b0},
        '{8'h1B, 1'b0, EXP_MODEL, 8'h00, 1'b0, 1'b0},
        '{8'h5C, 1'b1, EXP_ITEM,  8'h00, 1'b0, 1'b1}
    };

    always #4 clk = ~clk;

    // Advance the predictor by one byte; returns 1 when the byte yields an item.
    function automatic bit strip_byte(input logic [7:0] c, input logic eot, output clean_t r);
        logic       emit;
        logic [7:0] ob;
        logic       sep;
        logic [7:0] folded;
        emit   = 1'b0;
        ob     = 8'h00;
        sep    = (win_count != 0) && (win_last != CH_SPACE) && (win_last != CH_NL);
        folded = c | 8'h20;
        if (win_count < LIMIT)
        begin
            case (win_mode)
                PM_ESC:
                begin
                    if (c == CH_LBRACKET || c == CH_RBRACKET)
                    begin
                        win_mode = (c == CH_LBRACKET) ? PM_CSI : PM_OSC;
                        emit     = sep;
                        ob       = sep ? CH_SPACE : 8'h00;
                    end
                    else
                    begin
                        win_mode = PM_TEXT;
                    end
                end
                PM_CSI:
                begin
                    // Folding case maps both letter ranges onto lower case.
                    if (folded >= "a" && folded <= "z")
                        win_mode = PM_TEXT;
                end
                PM_OSC:
                begin
                    if (c == CH_BEL)
                        win_mode = PM_TEXT;
                    else if (c == CH_ESC)
                        win_mode = PM_OSC_ESC;
                end
                PM_OSC_ESC:
                begin
                    if (c == CH_BACKSLASH || c == CH_BEL)
                        win_mode = PM_TEXT;
                    else if (c != CH_ESC)
                        win_mode = PM_OSC;
                end
                default:
                begin
                    if (c == CH_ESC)
                    begin
                        win_mode = PM_ESC;
                    end
                    else
                    begin
                        win_mode = PM_TEXT;
                        if (c >= CH_SPACE || c == CH_NL || c == CH_TAB)
                        begin
                            emit = 1'b1;
                            ob   = c;
                        end
                    end
                end
            endcase
            if (emit)
            begin
                win_count = win_count + 12'd1;
                win_last  = ob;
            end
        end
        r.b       = emit ? ob : 8'h00;
        r.present = emit;
        r.mark    = eot;
        // The last byte of a window clears everything.
        if (eot)
        begin
            win_mode  = PM_TEXT;
            win_count = '0;
            win_last  = '0;
        end
        return emit || eot;
    endfunction

    // Offer one item, honouring the burst and gap pattern, and record its expectation.
    task automatic send_byte(input logic [7:0] b, input logic eot, input exp_kind_t kind,
                             input clean_t typed);
        clean_t r;
        bit     has;
        int     gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 5);
            if (gap != 0)
            begin
                rx_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
        end
        burst_left--;
        rx_if.valid       <= 1'b1;
        rx_if.in_byte     <= b;
        rx_if.end_of_text <= eot;
        do
            @(posedge clk);
        while (!rx_if.ready);
        has = strip_byte(b, eot, r);
        if (kind == EXP_NONE)
        begin
            has = 1'b0;
        end
        else if (kind == EXP_ITEM)
        begin
            has = 1'b1;
            r   = typed;
        end
        if (has)
            cleaned_q.push_back(r);
    endtask

    // Stop offering until every expected item has arrived.
    task automatic drain_wait();
        rx_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (cleaned_q.size() != 0);
    endtask

    // A run of plain text: printable bytes with the odd newline, tab or space.
    function automatic logic [7:0] text_byte();
        int s;
        s = $urandom_range(0, 15);
        if (s == 0)
            return CH_NL;
        else if (s == 1)
            return CH_TAB;
        else if (s == 2)
            return CH_SPACE;
        return 8'($urandom_range(8'h21, 8'hFF));
    endfunction

    // Append one lexical token (text, CSI, OSC, short escape, control or noise).
    task automatic add_token(input int text_pct);
        int n;
        int k;
        int term;
        logic [7:0] v;
        if ($urandom_range(0, 99) < text_pct)
        begin
            n = $urandom_range(1, 8);
            repeat (n) win_q.push_back(text_byte());
        end
        else
        begin
            k = $urandom_range(0, 5);
            case (k)
                0, 1:
                begin
                    // CSI: parameter bytes, then a final letter of either case.
                    win_q.push_back(CH_ESC);
                    win_q.push_back(CH_LBRACKET);
                    n = $urandom_range(0, 4);
                    repeat (n) win_q.push_back(8'($urandom_range(8'h30, 8'h3F)));
                    v = 8'($urandom_range(8'h41, 8'h5A));
                    win_q.push_back($urandom_range(0, 1) ? v : (v | 8'h20));
                end
                2:
                begin
                    // OSC with a random body, an odd escape that resumes it, and a terminator.
                    win_q.push_back(CH_ESC);
                    win_q.push_back(CH_RBRACKET);
                    n = $urandom_range(0, 6);
                    repeat (n) win_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
                    if ($urandom_range(0, 3) == 0)
                    begin
                        v = 8'($urandom_range(8'h20, 8'h7E));
                        win_q.push_back(CH_ESC);
                        win_q.push_back((v == CH_BACKSLASH) ? 8'h41 : v);
                        win_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
                    end
                    term = $urandom_range(0, 3);
                    if (term == 0)
                    begin
                        win_q.push_back(CH_BEL);
                    end
                    else
                    begin
                        win_q.push_back(CH_ESC);
                        if (term == 3)
                            win_q.push_back(CH_ESC);
                        win_q.push_back((term == 2) ? CH_BEL : CH_BACKSLASH);
                    end
                end
                3:
                begin
                    win_q.push_back(CH_ESC);
                    win_q.push_back(8'($urandom_range(0, 255)));
                end
                4:
                begin
                    win_q.push_back(8'($urandom_range(0, 31)));
                end
                default:
                begin
                    n = $urandom_range(1, 3);
                    repeat (n) win_q.push_back(8'($urandom_range(0, 255)));
                end
            endcase
        end
    endtask

    // Build a window of about the given length and send it, end flag on the last byte.
    task automatic send_window(input int target_len, input int text_pct);
        int len;
        win_q.delete();
        while (win_q.size() < target_len)
            add_token(text_pct);
        len = win_q.size();
        // Now and then cut the window short so a sequence is left open.
        if ($urandom_range(0, 5) == 0)
            len = $urandom_range(1, len);
        for (int i = 0; i < len; i++)
            send_byte(win_q[i], i == len - 1, EXP_MODEL, '0);
    endtask

    // Stimulus: reset, the directed table, then random windows.
    initial
    begin
        clean_t typed;
        int     rand_sent;
        int     win_n;
        int     len;
        clk               = 1'b0;
        rst_n             = 1'b0;
        rx_if.valid       = 1'b0;
        rx_if.in_byte     = '0;
        rx_if.end_of_text = 1'b0;
        win_mode          = PM_TEXT;
        win_count         = '0;
        win_last          = '0;
        fail_count        = 0;
        burst_left        = 0;
        rand_sent         = 0;
        win_n             = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_tab[i])
        begin
            typed.b       = dir_tab[i].t_b;
            typed.present = dir_tab[i].t_present;
            typed.mark    = dir_tab[i].t_mark;
            send_byte(dir_tab[i].b, dir_tab[i].eot, dir_tab[i].kind, typed);
        end

        while (rand_sent < RANDOM_ITEMS)
        begin
            if (win_n == 5 || win_n == 25)
                drain_wait();
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 30);
            send_window(len, 45);
            rand_sent += win_q.size();
            win_n++;
        end

        rx_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (cleaned_q.size() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Receiver: varying ready patterns, long hold-offs, and the item check.
    initial
    begin
        clean_t want;
        int     hold_left;
        int     next_hold_at;
        int     ready_mode;
        int     ready_phase;
        logic   rdy;
        tx_if.ready  = 1'b0;
        results_seen = 0;
        hold_left    = 0;
        next_hold_at = 60;
        ready_mode   = 0;
        ready_phase  = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && tx_if.valid && tx_if.ready)
            begin
                results_seen++;
                if (cleaned_q.size() == 0)
                begin
                    $error("unexpected item: out_byte %h byte_present %b end_mark %b",
                           tx_if.out_byte, tx_if.byte_present, tx_if.end_mark);
                    fail_count++;
                end
                else
                begin
                    want = cleaned_q.pop_front();
                    if (tx_if.out_byte !== want.b)
                    begin
                        $error("out_byte: expected %h, got %h", want.b, tx_if.out_byte);
                        fail_count++;
                    end
                    if (tx_if.byte_present !== want.present)
                    begin
                        $error("byte_present: expected %b, got %b",
                               want.present, tx_if.byte_present);
                        fail_count++;
                    end
                    if (tx_if.end_mark !== want.mark)
                    begin
                        $error("end_mark: expected %b, got %b", want.mark, tx_if.end_mark);
                        fail_count++;
                    end
                end
            end

            // Pick the ready value for the next cycle.
            ready_phase++;
            if (ready_phase % 50 == 0)
                ready_mode = $urandom_range(0, 3);
            if (hold_left > 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else if (results_seen >= next_hold_at)
            begin
                hold_left     = 80;
                next_hold_at += 500;
                rdy           = 1'b0;
            end
            else
            begin
                case (ready_mode)
                    0:       rdy = 1'b1;
                    1:       rdy = ($urandom_range(0, 1) == 1);
                    2:       rdy = (ready_phase % 4 != 0);
                    default: rdy = ($urandom_range(0, 99) < 85);
                endcase
            end
            tx_if.ready <= rdy;
        end
    end

    // Watchdog on the whole run.
    initial
    begin
        cycle_n = 0;
        while (cycle_n < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_n++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- sim.f -----
design/aes_pkg.sv
design/aes_if.sv
design/aes_in_stage.sv
design/aes_parser.sv
design/aes_out_stage.sv
design/ansi_escape_stripper.sv
bench/tb.sv
